@@ rtl/core/fdss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and the segment table for the four-digit
// seven-segment scan core.
// ----------------------------------------------------------------------------
package fdss_pkg;

  localparam int unsigned NUM_DIGITS = 4;

  // reciprocal constants, quotient = (x * RECIP) >> SHIFT, exact over the stated range
  localparam logic [28:0] RECIP_625  = 29'd439804652;  // x < 2^28, shift 38
  localparam int unsigned SHIFT_625  = 38;
  localparam logic [14:0] RECIP_1000 = 15'd16778;      // x < 10000, shift 24
  localparam logic [9:0]  RECIP_100  = 10'd656;        // x < 1000, shift 16
  localparam logic [6:0]  RECIP_10   = 7'd103;         // x < 100, shift 10

  localparam logic [9:0] DIV_625  = 10'd625;
  localparam logic [9:0] DIV_1000 = 10'd1000;
  localparam logic [6:0] DIV_100  = 7'd100;
  localparam logic [3:0] DIV_10   = 4'd10;

  localparam logic [7:0] BLANK_PATTERN = 8'h00;
  localparam logic [3:0] SELECT_TOP    = 4'b1000;
  localparam logic [1:0] POS_LAST      = 2'd3;

  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  // common-cathode pattern, bit 0 segment a
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0: p = 8'h3F;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5B;
      4'd3: p = 8'h4F;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6D;
      4'd6: p = 8'h7D;
      4'd7: p = 8'h27;
      4'd8: p = 8'h7F;
      4'd9: p = 8'h67;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fdss_digits.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_digits
// Nine-stage pipeline that takes a 32-bit value modulo 10000 and splits the
// result into four decimal digits with reciprocal multiplies.
// ----------------------------------------------------------------------------
module fdss_digits (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [31:0]      in_value,
  output logic                  dig_valid,
  output fdss_pkg::digits_t     dig
);

  // valid bits
  logic [8:0] vld_r;

  // stage 1: (value >> 4) * recip(625)
  logic [56:0] prod1_nxt, prod1_r;
  logic [27:0] q1_r;
  logic [3:0]  low1_r;

  // stage 2: quotient * 625
  logic [18:0] quo2;
  logic [27:0] quo625_nxt, quo625_r, q2_r;
  logic [3:0]  low2_r;

  // stage 3: m = value mod 10000, times recip(1000)
  logic [27:0] diff3;
  logic [13:0] m3_nxt, m3_r;
  logic [28:0] p3_nxt, p3_r;

  // stage 4: thousands digit and its weight
  logic [3:0]  d3_4;
  logic [13:0] t4_nxt, t4_r, m4_r;
  logic [3:0]  d3_4_r;

  // stage 5: r3 = m mod 1000, times recip(100)
  logic [13:0] diff5;
  logic [9:0]  r3_5;
  logic [19:0] p5_nxt, p5_r;
  logic [9:0]  r3_5_r;
  logic [3:0]  d3_5_r;

  // stage 6: hundreds digit and its weight
  logic [3:0]  d2_6;
  logic [9:0]  t6_nxt, t6_r, r3_6_r;
  logic [3:0]  d3_6_r, d2_6_r;

  // stage 7: r2 = m mod 100, times recip(10)
  logic [9:0]  diff7;
  logic [6:0]  r2_7;
  logic [13:0] p7_nxt, p7_r;
  logic [6:0]  r2_7_r;
  logic [3:0]  d3_7_r, d2_7_r;

  // stage 8: tens digit and its weight
  logic [3:0]  d1_8;
  logic [6:0]  t8_nxt, t8_r, r2_8_r;
  logic [3:0]  d3_8_r, d2_8_r, d1_8_r;

  // stage 9: ones digit
  logic [6:0]  diff9;
  fdss_pkg::digits_t dig_nxt, dig_r;

  assign prod1_nxt  = 57'(in_value[31:4]) * 57'(fdss_pkg::RECIP_625);

  assign quo2       = prod1_r[56:fdss_pkg::SHIFT_625];
  assign quo625_nxt = 28'(quo2) * 28'(fdss_pkg::DIV_625);

  assign diff3      = q2_r - quo625_r;
  assign m3_nxt     = {diff3[9:0], low2_r};
  assign p3_nxt     = 29'(m3_nxt) * 29'(fdss_pkg::RECIP_1000);

  assign d3_4       = p3_r[27:24];
  assign t4_nxt     = 14'(d3_4) * 14'(fdss_pkg::DIV_1000);

  assign diff5      = m4_r - t4_r;
  assign r3_5       = diff5[9:0];
  assign p5_nxt     = 20'(r3_5) * 20'(fdss_pkg::RECIP_100);

  assign d2_6       = p5_r[19:16];
  assign t6_nxt     = 10'(d2_6) * 10'(fdss_pkg::DIV_100);

  assign diff7      = r3_6_r - t6_r;
  assign r2_7       = diff7[6:0];
  assign p7_nxt     = 14'(r2_7) * 14'(fdss_pkg::RECIP_10);

  assign d1_8       = p7_r[13:10];
  assign t8_nxt     = 7'(d1_8) * 7'(fdss_pkg::DIV_10);

  assign diff9      = r2_8_r - t8_r;

  always_comb begin
    dig_nxt.d3 = d3_8_r;
    dig_nxt.d2 = d2_8_r;
    dig_nxt.d1 = d1_8_r;
    dig_nxt.d0 = diff9[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    prod1_r  <= prod1_nxt;
    q1_r     <= in_value[31:4];
    low1_r   <= in_value[3:0];

    quo625_r <= quo625_nxt;
    q2_r     <= q1_r;
    low2_r   <= low1_r;

    m3_r     <= m3_nxt;
    p3_r     <= p3_nxt;

    t4_r     <= t4_nxt;
    m4_r     <= m3_r;
    d3_4_r   <= d3_4;

    p5_r     <= p5_nxt;
    r3_5_r   <= r3_5;
    d3_5_r   <= d3_4_r;

    t6_r     <= t6_nxt;
    r3_6_r   <= r3_5_r;
    d3_6_r   <= d3_5_r;
    d2_6_r   <= d2_6;

    p7_r     <= p7_nxt;
    r2_7_r   <= r2_7;
    d3_7_r   <= d3_6_r;
    d2_7_r   <= d2_6_r;

    t8_r     <= t8_nxt;
    r2_8_r   <= r2_7_r;
    d3_8_r   <= d3_7_r;
    d2_8_r   <= d2_7_r;
    d1_8_r   <= d1_8;

    dig_r    <= dig_nxt;
  end

  assign dig_valid = vld_r[8];
  assign dig       = dig_r;

endmodule
`default_nettype wire

@@ rtl/core/four_digit_seven_segment_scan_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_core
// Shows the four lowest decimal digits of a 32-bit value as a four-step
// multiplexed scan of active-low seven-segment drives, ones digit first.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its first result
// strobes after the nine-stage digit pipeline and the scan register, and the
// remaining three follow, one per cycle. The receiver cannot stall: out_strobe
// marks each result for exactly one cycle. Each accept sets a down-counter that
// holds busy high, spacing items by the time the single result port needs to
// scan out four digits; a new item can enter before the last leaves the
// pipeline. A zero thousands digit is blanked (segment drive all ones).
module four_digit_seven_segment_scan_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  output logic             out_strobe,
  output logic [1:0]       out_position,
  output logic [3:0]       out_module_select,
  output logic [7:0]       out_segment_drive,
  output logic             out_last
);

  logic              accept;
  logic [1:0]        busy_cnt_r, busy_cnt_nxt;
  logic              dig_valid;
  fdss_pkg::digits_t dig;

  logic              strobe_r, strobe_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [7:0]        seg_r, seg_nxt;
  logic [23:0]       shift_r, shift_nxt;
  logic [7:0]        pat3;

  assign accept = start && !busy;
  assign busy   = (busy_cnt_r != 2'd0);

  always_comb begin
    busy_cnt_nxt = busy_cnt_r;
    if (accept) begin
      busy_cnt_nxt = 2'd3;
    end else if (busy) begin
      busy_cnt_nxt = busy_cnt_r - 2'd1;
    end
  end

  fdss_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_value  (in_value),
    .dig_valid (dig_valid),
    .dig       (dig)
  );

  // thousands digit blanked when zero
  assign pat3 = (dig.d3 == 4'd0) ? fdss_pkg::BLANK_PATTERN : fdss_pkg::seg_pattern(dig.d3);

  always_comb begin
    strobe_nxt = 1'b0;
    pos_nxt    = pos_r;
    seg_nxt    = seg_r;
    shift_nxt  = shift_r;
    if (dig_valid) begin
      strobe_nxt = 1'b1;
      pos_nxt    = 2'd0;
      seg_nxt    = ~fdss_pkg::seg_pattern(dig.d0);
      shift_nxt  = {~pat3, ~fdss_pkg::seg_pattern(dig.d2), ~fdss_pkg::seg_pattern(dig.d1)};
    end else if (strobe_r && pos_r != fdss_pkg::POS_LAST) begin
      strobe_nxt = 1'b1;
      pos_nxt    = pos_r + 2'd1;
      seg_nxt    = shift_r[7:0];
      shift_nxt  = {8'h00, shift_r[23:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= 2'd0;
      strobe_r   <= 1'b0;
      pos_r      <= 2'd0;
    end else begin
      busy_cnt_r <= busy_cnt_nxt;
      strobe_r   <= strobe_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r   <= seg_nxt;
    shift_r <= shift_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_position      = pos_r;
  assign out_module_select = fdss_pkg::SELECT_TOP >> pos_r;
  assign out_segment_drive = seg_r;
  assign out_last          = (pos_r == fdss_pkg::POS_LAST);

  // scan steps through positions in order without gaps
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_position != 2'd0) |->
      ($past(out_strobe) && out_position == $past(out_position) + 2'd1))
    else $error("scan position out of order");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy ##1 busy)
    else $error("busy not held after accept");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot(out_module_select))
    else $error("module select not one-hot");

  a_new_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_position == 2'd0) |-> !$past(out_strobe) || $past(out_last))
    else $error("scan restarted before the previous one finished");

endmodule
`default_nettype wire
